>>> hw/rtl/tlf_pkg.sv
package tlf_pkg;

   // Field and register widths.
   localparam int CHAR_W      = 8;
   localparam int FOLD_W      = 6;
   localparam int TAB_W       = 4;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 1;

   // Line buffer depth used unless the top level is given another.
   localparam int BUFFER_CHARS_DEFAULT = 32;

   // Register values after reset.
   localparam logic [FOLD_W-1:0] FOLD_WIDTH_RESET = 6'd20;
   localparam logic [TAB_W-1:0]  TAB_WIDTH_RESET  = 4'd8;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOLD_WIDTH = 1'b0,
      CSR_TAB_WIDTH  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SPACE,
      ST_WCHK,
      ST_DROP,
      ST_CUT,
      ST_CLEAR,
      ST_ERD,
      ST_EWR,
      ST_ENL
   } state_type;

   typedef enum logic [1:0] {
      PH_HOLD,
      PH_ADVANCE,
      PH_ZERO
   } phase_op_type;

   typedef enum logic [1:0] {
      SRC_FLUSH,
      SRC_BP,
      SRC_HC
   } emit_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch_in;
      phase_op_type phase_op;
      logic         cnt_load_tab;
      logic         cnt_dec;
      logic         append_word;
      logic         append_space;
      logic         space_mark;
      logic         clear_line;
      logic         drop;
      logic         cut;
      logic         emit_setup;
      emit_src_type emit_src;
      logic         rd_first;
      logic         rd_next;
      logic         out_char;
      logic         out_nl;
      logic         out_last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_eot;
      logic is_nl;
      logic is_tab;
      logic is_sp;
      logic line_begun;
      logic width_full;
      logic bp_zero;
      logic flush_zero;
      logic refold;
      logic emit_empty;
      logic emit_more;
      logic cnt_last;
      logic can_load;
   } dp_status_type;

endpackage

>>> hw/rtl/tlf_if.sv
interface tlf_req_if;
   import tlf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              end_of_text;

   modport source (output valid, output in_char, output end_of_text, input ready);
   modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

interface tlf_rsp_if;
   import tlf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> hw/rtl/tlf_ctrl.sv
module tlf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tlf_pkg::dp_status_type status,
   output tlf_pkg::dp_cmd_type    cmd
);
   import tlf_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      nl_last_ff, nl_last_in;

   // State register, return state after an emitted line, and its last flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         nl_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         nl_last_ff <= nl_last_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      cmd          = '0;
      cmd.phase_op = PH_HOLD;
      cmd.emit_src = SRC_FLUSH;
      state_in     = state_ff;
      ret_in       = ret_ff;
      nl_last_in   = nl_last_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (status.is_eot) begin
               cmd.phase_op = PH_ZERO;
               if (status.flush_zero) begin
                  state_in = ST_CLEAR;
               end else begin
                  cmd.emit_setup = 1'b1;
                  cmd.emit_src   = SRC_FLUSH;
                  nl_last_in     = 1'b1;
                  ret_in         = ST_CLEAR;
                  state_in       = ST_ERD;
               end
            end else if (status.is_nl) begin
               cmd.phase_op   = PH_ZERO;
               cmd.emit_setup = 1'b1;
               cmd.emit_src   = SRC_FLUSH;
               nl_last_in     = 1'b1;
               ret_in         = ST_CLEAR;
               state_in       = ST_ERD;
            end else if (status.is_tab) begin
               // Every tab ends on a tab stop, so the phase goes to zero at once.
               cmd.phase_op     = PH_ZERO;
               cmd.cnt_load_tab = 1'b1;
               state_in         = ST_SPACE;
            end else if (status.is_sp) begin
               // A single space is handled in this step.
               cmd.phase_op = PH_ADVANCE;
               if (!status.line_begun) begin
                  state_in = ST_IDLE;
               end else if (status.width_full) begin
                  cmd.space_mark = 1'b1;
                  cmd.emit_setup = 1'b1;
                  cmd.emit_src   = SRC_FLUSH;
                  nl_last_in     = 1'b1;
                  ret_in         = ST_CLEAR;
                  state_in       = ST_ERD;
               end else begin
                  cmd.space_mark   = 1'b1;
                  cmd.append_space = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               cmd.phase_op = PH_ADVANCE;
               if (status.width_full && !status.bp_zero) begin
                  cmd.emit_setup = 1'b1;
                  cmd.emit_src   = SRC_BP;
                  nl_last_in     = !status.refold;
                  ret_in         = ST_DROP;
                  state_in       = ST_ERD;
               end else if (status.width_full) begin
                  cmd.emit_setup = 1'b1;
                  cmd.emit_src   = SRC_HC;
                  nl_last_in     = 1'b1;
                  ret_in         = ST_CUT;
                  state_in       = ST_ERD;
               end else begin
                  cmd.append_word = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end

         // One expanded tab space per cycle.
         ST_SPACE: begin
            if (!status.line_begun) begin
               state_in = ST_IDLE;
            end else if (status.width_full) begin
               cmd.space_mark = 1'b1;
               cmd.emit_setup = 1'b1;
               cmd.emit_src   = SRC_FLUSH;
               nl_last_in     = 1'b1;
               ret_in         = ST_CLEAR;
               state_in       = ST_ERD;
            end else begin
               cmd.space_mark   = 1'b1;
               cmd.append_space = 1'b1;
               if (status.cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.cnt_dec = 1'b1;
               end
            end
         end

         // Word character after a fold: check the width again, then store it.
         ST_WCHK: begin
            if (status.width_full && !status.bp_zero) begin
               cmd.emit_setup = 1'b1;
               cmd.emit_src   = SRC_BP;
               nl_last_in     = !status.refold;
               ret_in         = ST_DROP;
               state_in       = ST_ERD;
            end else if (status.width_full) begin
               cmd.emit_setup = 1'b1;
               cmd.emit_src   = SRC_HC;
               nl_last_in     = 1'b1;
               ret_in         = ST_CUT;
               state_in       = ST_ERD;
            end else begin
               cmd.append_word = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         ST_DROP: begin
            cmd.drop = 1'b1;
            state_in = ST_WCHK;
         end

         ST_CUT: begin
            cmd.cut  = 1'b1;
            state_in = ST_WCHK;
         end

         ST_CLEAR: begin
            cmd.clear_line = 1'b1;
            state_in       = ST_IDLE;
         end

         // Start reading the held line, or go straight to the newline.
         ST_ERD: begin
            if (status.emit_empty) begin
               state_in = ST_ENL;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = ST_EWR;
            end
         end

         // One held character per transfer slot; the next read runs alongside.
         ST_EWR: begin
            if (status.can_load) begin
               cmd.out_char = 1'b1;
               if (status.emit_more) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = ST_ENL;
               end
            end
         end

         ST_ENL: begin
            if (status.can_load) begin
               cmd.out_nl   = 1'b1;
               cmd.out_last = nl_last_ff;
               state_in     = ret_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/tlf_datapath.sv
module tlf_datapath #(
   parameter int BUFFER_CHARS = tlf_pkg::BUFFER_CHARS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tlf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [tlf_pkg::CHAR_W-1:0]      in_char,
   input  logic                            end_of_text,
   output logic [tlf_pkg::CHAR_W-1:0]      out_char,
   output logic                            last_of_run,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  tlf_pkg::dp_cmd_type             cmd,
   output tlf_pkg::dp_status_type          status
);
   import tlf_pkg::*;

   localparam int AW = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;
   localparam int CW = $clog2(BUFFER_CHARS + 1);

   // Configuration registers.
   logic [FOLD_W-1:0] fold_width_ff, fold_width_in;
   logic [TAB_W-1:0]  tab_width_ff, tab_width_in;

   // Line state. The held line is a ring in the store starting at base_ff.
   logic [CW-1:0]    hc_ff, hc_in;
   logic [CW-1:0]    bp_ff, bp_in;
   logic [CW-1:0]    ws_ff, ws_in;
   logic             wsv_ff, wsv_in;
   logic             iw_ff, iw_in;
   logic             lb_ff, lb_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [TAB_W-1:0] phase_ff, phase_in;
   logic [TAB_W-1:0] cnt_ff, cnt_in;

   // Emission counters and the latched input item.
   logic [CW-1:0]     elen_ff, elen_in;
   logic [CW-1:0]     ei_ff, ei_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              eot_ff, eot_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;

   logic [CHAR_W-1:0] line_mem [BUFFER_CHARS];
   logic [CHAR_W-1:0] rd_data_ff;

   logic [CW-1:0]    w_eff;
   logic [TAB_W-1:0] tw_eff;
   logic [TAB_W-1:0] tab_n;
   logic [TAB_W:0]   phase_inc;
   logic [CW-1:0]    flush_end;
   logic [CW-1:0]    drop_k;
   logic [CW-1:0]    ei_inc;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;

   // Logical position in the held line to a store address.
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(idx);
      if (sum >= (CW+1)'(BUFFER_CHARS)) begin
         sum = sum - (CW+1)'(BUFFER_CHARS);
      end
      return sum[AW-1:0];
   endfunction

   // Effective fold width and tab width, and the tab's space count.
   always_comb begin
      if (fold_width_ff == '0) begin
         w_eff = CW'(1);
      end else if ((FOLD_W+1)'(fold_width_ff) > (FOLD_W+1)'(BUFFER_CHARS)) begin
         w_eff = CW'(BUFFER_CHARS);
      end else begin
         w_eff = CW'(fold_width_ff);
      end
      tw_eff    = (tab_width_ff == '0) ? TAB_W'(1) : tab_width_ff;
      tab_n     = (phase_ff < tw_eff) ? (tw_eff - phase_ff) : TAB_W'(1);
      phase_inc = (TAB_W+1)'(phase_ff) + (TAB_W+1)'(1);
      flush_end = !lb_ff ? '0 : (iw_ff ? hc_ff : bp_ff);
      // Spaces after the break point are dropped along with the emitted part.
      drop_k    = wsv_ff ? ws_ff : hc_ff;
      ei_inc    = ei_ff + CW'(1);
      rd_addr   = phys_addr(base_ff, cmd.rd_first ? '0 : ei_inc);
      wr_addr   = phys_addr(base_ff, hc_ff);
   end

   // Status for the controller.
   always_comb begin
      status.is_eot     = eot_ff;
      status.is_nl      = (char_ff == CH_NL);
      status.is_tab     = (char_ff == CH_TAB);
      status.is_sp      = (char_ff == CH_SP);
      status.line_begun = lb_ff;
      status.width_full = (hc_ff >= w_eff);
      status.bp_zero    = (bp_ff == '0);
      status.flush_zero = (flush_end == '0);
      status.refold     = ((hc_ff - drop_k) >= w_eff);
      status.emit_empty = (elen_ff == '0);
      status.emit_more  = (ei_inc < elen_ff);
      status.cnt_last   = (cnt_ff == TAB_W'(1));
      status.can_load   = !out_valid_ff || rsp_ready;
   end

   // Next values of all registers.
   always_comb begin
      fold_width_in = fold_width_ff;
      tab_width_in  = tab_width_ff;
      hc_in         = hc_ff;
      bp_in         = bp_ff;
      ws_in         = ws_ff;
      wsv_in        = wsv_ff;
      iw_in         = iw_ff;
      lb_in         = lb_ff;
      base_in       = base_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      elen_in       = elen_ff;
      ei_in         = ei_ff;
      char_in       = char_ff;
      eot_in        = eot_ff;
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;

      // Register writes.
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FOLD_WIDTH: fold_width_in = csr_wdata[FOLD_W-1:0];
            CSR_TAB_WIDTH:  tab_width_in  = csr_wdata[TAB_W-1:0];
         endcase
      end

      if (cmd.latch_in) begin
         char_in = in_char;
         eot_in  = end_of_text;
      end

      // Input column modulo the tab width.
      case (cmd.phase_op)
         PH_ADVANCE: phase_in = (phase_inc >= (TAB_W+1)'(tw_eff)) ? '0 : phase_inc[TAB_W-1:0];
         PH_ZERO:    phase_in = '0;
         default:    phase_in = phase_ff;
      endcase

      if (cmd.cnt_load_tab) begin
         cnt_in = tab_n;
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - TAB_W'(1);
      end

      // A space right after a word marks a break point.
      if (cmd.space_mark) begin
         iw_in = 1'b0;
         if (iw_ff) begin
            bp_in  = hc_ff;
            wsv_in = 1'b0;
         end
      end

      if (cmd.append_space) begin
         hc_in = hc_ff + CW'(1);
      end

      // A word character; the first of a word records where the word starts.
      if (cmd.append_word) begin
         hc_in = hc_ff + CW'(1);
         lb_in = 1'b1;
         iw_in = 1'b1;
         if (!iw_ff) begin
            ws_in  = hc_ff;
            wsv_in = 1'b1;
         end
      end

      if (cmd.drop) begin
         base_in = phys_addr(base_ff, drop_k);
         hc_in   = hc_ff - drop_k;
         bp_in   = '0;
         wsv_in  = 1'b0;
      end

      if (cmd.cut) begin
         hc_in  = '0;
         bp_in  = '0;
         wsv_in = 1'b0;
      end

      if (cmd.clear_line) begin
         hc_in  = '0;
         bp_in  = '0;
         wsv_in = 1'b0;
         iw_in  = 1'b0;
         lb_in  = 1'b0;
      end

      // Length of the line part about to be emitted.
      if (cmd.emit_setup) begin
         case (cmd.emit_src)
            SRC_BP:  elen_in = bp_ff;
            SRC_HC:  elen_in = hc_ff;
            default: elen_in = flush_end;
         endcase
      end

      if (cmd.rd_first) begin
         ei_in = '0;
      end else if (cmd.rd_next) begin
         ei_in = ei_inc;
      end

      // Output register: loaded by the controller, emptied by a transfer.
      if (cmd.out_char) begin
         out_valid_in = 1'b1;
         out_char_in  = rd_data_ff;
         out_last_in  = 1'b0;
      end else if (cmd.out_nl) begin
         out_valid_in = 1'b1;
         out_char_in  = CH_NL;
         out_last_in  = cmd.out_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_width_ff <= FOLD_WIDTH_RESET;
         tab_width_ff  <= TAB_WIDTH_RESET;
         hc_ff         <= '0;
         bp_ff         <= '0;
         wsv_ff        <= 1'b0;
         iw_ff         <= 1'b0;
         lb_ff         <= 1'b0;
         base_ff       <= '0;
         phase_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         fold_width_ff <= fold_width_in;
         tab_width_ff  <= tab_width_in;
         hc_ff         <= hc_in;
         bp_ff         <= bp_in;
         wsv_ff        <= wsv_in;
         iw_ff         <= iw_in;
         lb_ff         <= lb_in;
         base_ff       <= base_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ws_ff       <= ws_in;
      cnt_ff      <= cnt_in;
      elen_ff     <= elen_in;
      ei_ff       <= ei_in;
      char_ff     <= char_in;
      eot_ff      <= eot_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Line store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.append_word || cmd.append_space) begin
         line_mem[wr_addr] <= cmd.append_word ? char_ff : CH_SP;
      end
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign out_char    = out_char_ff;
   assign last_of_run = out_last_ff;

endmodule

>>> hw/rtl/text_line_folder.sv
// Text line folder: greedy word wrap with tab expansion.
// The req channel takes one character per transfer (in_char, or end_of_text to
// flush the pending line). The rsp channel returns the folded text one byte per
// transfer; last_of_run marks the final byte caused by one input character.
// A character that is simply held (word character or space) takes the transfer
// and one update step; a tab then takes one step per expanded space. An input
// that emits a line of k held characters loads them from the store, then a newline;
// each store read is registered and issued ahead of its output load, so the store
// read sets one character per cycle while rsp does not stall, and a fold that cuts
// a long word adds a second line. A new character is accepted
// only once the current one is done; the last result may still sit in the output
// register. When rsp stalls, the output register holds its byte and the
// emission sequencer waits. Synchronous reset restores fold width 20, tab width
// 8, an empty line and an empty output register. The csr port takes writes at
// any time, but they are meant for an idle block.
module text_line_folder #(
   parameter int BUFFER_CHARS = tlf_pkg::BUFFER_CHARS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   tlf_req_if.sink                         req_ch,
   tlf_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [tlf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tlf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   logic [CHAR_W-1:0] out_char;
   logic          last_of_run;

   tlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlf_datapath #(
      .BUFFER_CHARS (BUFFER_CHARS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_char     (req_ch.in_char),
      .end_of_text (req_ch.end_of_text),
      .out_char    (out_char),
      .last_of_run (last_of_run),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .status      (status)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.out_char    = out_char;
   assign rsp_ch.last_of_run = last_of_run;

endmodule

>>> hw/rtl/tlf_checker.sv
module tlf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tlf_pkg::CHAR_W-1:0] out_char,
   input logic                       last_of_run
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_char) && $stable(last_of_run))
      else $error("result payload changed while stalled");

   // One character is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again right after a transfer");

   // While a run is still open, no new character is taken.
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |-> !req_ready)
      else $error("input ready while a run of results is unfinished");

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_char    (rsp_ch.out_char),
   .last_of_run (rsp_ch.last_of_run)
);

>>> sim/tb.sv
module tb;
   import tlf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int      PERIOD_NS      = 12;
   localparam int      BUF_CHARS      = BUFFER_CHARS_DEFAULT;
   localparam int      MAX_RESULTS    = 34;
   localparam int      SETTLE_CYCLES  = 40;
   localparam int      HOLD_OFF_CYCLES = 300;
   localparam int      PHASES         = 8;
   localparam int      PHASE_ITEMS    = 45;
   localparam longint  WATCHDOG_NS    = 64'd7_200_000;

   // Directed rows either write a register, offer a character or end the text.
   typedef enum logic [1:0] {
      ROW_CHAR,
      ROW_EOT,
      ROW_FOLD,
      ROW_TAB
   } row_kind_type;

   // How the result of a directed row is known: from the predictor, typed in, or not checked.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_NL
   } check_mode_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [7:0]     value;
      check_mode_type check;
   } stim_row_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_byte_type;

   localparam int DIRECTED_ROWS = 34;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Reset settings: blank line, then end of text with nothing held.
      '{ROW_CHAR, CH_NL,  CHK_NL},
      '{ROW_EOT,  8'h00,  CHK_NONE},
      // Width four: leading blank, extreme bytes, fold, hard cut, tab.
      '{ROW_FOLD, 8'd4,   CHK_MODEL},
      '{ROW_TAB,  8'd1,   CHK_MODEL},
      '{ROW_CHAR, CH_SP,  CHK_NONE},
      '{ROW_CHAR, 8'h00,  CHK_NONE},
      '{ROW_CHAR, 8'hFF,  CHK_NONE},
      '{ROW_CHAR, CH_SP,  CHK_NONE},
      '{ROW_CHAR, "c",    CHK_NONE},
      '{ROW_CHAR, "d",    CHK_MODEL},
      '{ROW_CHAR, "e",    CHK_MODEL},
      '{ROW_CHAR, "f",    CHK_MODEL},
      '{ROW_CHAR, "g",    CHK_MODEL},
      '{ROW_CHAR, CH_TAB, CHK_MODEL},
      '{ROW_CHAR, CH_NL,  CHK_MODEL},
      // Width zero and tab width zero both act as one.
      '{ROW_FOLD, 8'd0,   CHK_MODEL},
      '{ROW_TAB,  8'd0,   CHK_MODEL},
      '{ROW_CHAR, "p",    CHK_MODEL},
      '{ROW_CHAR, "q",    CHK_MODEL},
      '{ROW_CHAR, CH_TAB, CHK_MODEL},
      '{ROW_EOT,  8'h5A,  CHK_MODEL},
      // Oversized width, then the tab width and the width lowered mid-line.
      '{ROW_FOLD, 8'd63,  CHK_MODEL},
      '{ROW_TAB,  8'd15,  CHK_MODEL},
      '{ROW_CHAR, "u",    CHK_MODEL},
      '{ROW_CHAR, "v",    CHK_MODEL},
      '{ROW_CHAR, "w",    CHK_MODEL},
      '{ROW_TAB,  8'd2,   CHK_MODEL},
      '{ROW_CHAR, CH_TAB, CHK_MODEL},
      '{ROW_CHAR, "z",    CHK_MODEL},
      '{ROW_CHAR, "z",    CHK_MODEL},
      '{ROW_CHAR, "z",    CHK_MODEL},
      '{ROW_CHAR, "z",    CHK_MODEL},
      '{ROW_FOLD, 8'd3,   CHK_MODEL},
      '{ROW_CHAR, "k",    CHK_MODEL}
   };

   // Register settings and sender/receiver idling of each random phase.
   localparam logic [FOLD_W-1:0] PHASE_FOLD [PHASES] = '{
      6'd12, 6'd4, 6'd32, 6'd63, 6'd0, 6'd1, 6'd20, 6'd20
   };
   localparam logic [TAB_W-1:0] PHASE_TAB [PHASES] = '{
      4'd4, 4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd8, 4'd8
   };
   localparam bit PHASE_IDLE [PHASES] = '{1, 0, 1, 1, 1, 1, 1, 0};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tlf_req_if req_bus ();
   tlf_rsp_if rsp_bus ();

   text_line_folder #(
      .BUFFER_CHARS(BUF_CHARS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_bus),
      .rsp_ch   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // Predictor state: registers, held line and column tracking.
   logic [FOLD_W-1:0] fold_limit;
   logic [TAB_W-1:0]  tab_span;
   logic [7:0]        line_buf [BUF_CHARS];
   logic [5:0]        held_n;
   logic [5:0]        word_end;
   bit                in_word;
   bit                line_open;
   logic [3:0]        tab_col;

   text_byte_type  step_text [$];
   text_byte_type  pending_text [$];
   check_mode_type offered_check;
   int             fail_count = 0;
   bit             gaps_on = 1'b0;
   bit             stalls_on = 1'b0;
   bit             hold_off_pending = 1'b0;
   int             word_left = 0;

   function automatic void log_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic int unsigned line_limit();
      int unsigned w;
      w = 32'(fold_limit);
      if (w < 1) w = 1;
      if (w > BUF_CHARS) w = BUF_CHARS;
      return w;
   endfunction

   function automatic void push_byte(logic [7:0] c);
      if (step_text.size() < MAX_RESULTS) begin
         step_text.push_back('{ch: c, last: 1'b0});
      end
   endfunction

   // Send the first k held characters, then a newline.
   function automatic void emit_line(int unsigned k);
      int unsigned i;
      if (k > held_n) k = 32'(held_n);
      for (i = 0; i < k; i++) push_byte(line_buf[i]);
      push_byte(CH_NL);
   endfunction

   function automatic void start_line();
      held_n = '0;
      word_end = '0;
      in_word = 1'b0;
      line_open = 1'b0;
   endfunction

   // Remove k characters and the blanks after them from the front of the line.
   function automatic void drop_upto(int unsigned k);
      int unsigned i;
      if (k > held_n) k = 32'(held_n);
      while (k < held_n && line_buf[k] == CH_SP) k++;
      for (i = 0; i < held_n - k; i++) line_buf[i] = line_buf[i + k];
      held_n = 6'(held_n - k);
      word_end = '0;
      line_open = (held_n != 0);
      if (!line_open) in_word = 1'b0;
   endfunction

   function automatic void hold_byte(logic [7:0] c);
      if (held_n < BUF_CHARS) begin
         line_buf[held_n] = c;
         held_n++;
      end
   endfunction

   function automatic void step_column();
      int unsigned tw;
      tw = (tab_span == 0) ? 1 : 32'(tab_span);
      tab_col = (tab_col + 1 >= tw) ? 4'd0 : tab_col + 4'd1;
   endfunction

   // A blank closes the current word; at full width it folds the line.
   function automatic void take_blank();
      step_column();
      if (!line_open) return;
      if (in_word) begin
         word_end = held_n;
         in_word = 1'b0;
      end
      if (held_n >= line_limit()) begin
         emit_line(32'(word_end));
         start_line();
         return;
      end
      hold_byte(CH_SP);
   endfunction

   // A word character at full width folds at the last word end, or cuts hard.
   function automatic void take_word(logic [7:0] c);
      int unsigned w;
      w = line_limit();
      step_column();
      if (held_n >= w) begin
         if (word_end > 0) begin
            emit_line(32'(word_end));
            drop_upto(32'(word_end));
         end
         if (held_n >= w) begin
            emit_line(32'(held_n));
            held_n = '0;
            word_end = '0;
         end
      end
      hold_byte(c);
      line_open = 1'b1;
      in_word = 1'b1;
   endfunction

   function automatic int unsigned flush_point();
      if (!line_open) return 0;
      return in_word ? 32'(held_n) : 32'(word_end);
   endfunction

   // Work out the bytes that one accepted input causes.
   function automatic void fold_char(logic [7:0] c, logic eot);
      int unsigned e;
      int unsigned tw;
      int unsigned n;
      int unsigned i;
      step_text.delete();
      if (eot) begin
         e = flush_point();
         if (e > 0) emit_line(e);
         start_line();
         tab_col = '0;
      end else if (c == CH_NL) begin
         emit_line(flush_point());
         start_line();
         tab_col = '0;
      end else if (c == CH_TAB) begin
         tw = (tab_span == 0) ? 1 : 32'(tab_span);
         n = (tab_col < tw) ? tw - 32'(tab_col) : 1;
         for (i = 0; i < n; i++) take_blank();
      end else if (c == CH_SP) begin
         take_blank();
      end else begin
         take_word(c);
      end
      if (step_text.size() > 0) step_text[step_text.size() - 1].last = 1'b1;
   endfunction

   // Scoreboard: check output transfers, track register writes, predict inputs.
   always @(posedge clock) begin
      text_byte_type want;
      if (reset) begin
         fold_limit = FOLD_WIDTH_RESET;
         tab_span = TAB_WIDTH_RESET;
         foreach (line_buf[i]) line_buf[i] = 8'h00;
         start_line();
         tab_col = '0;
         pending_text.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_text.size() == 0) begin
               log_failure($sformatf("unexpected byte %h last %b",
                                     rsp_bus.out_char, rsp_bus.last_of_run));
            end else begin
               want = pending_text.pop_front();
               if (rsp_bus.out_char !== want.ch || rsp_bus.last_of_run !== want.last) begin
                  log_failure($sformatf("expected byte %h last %b, got byte %h last %b",
                                        want.ch, want.last,
                                        rsp_bus.out_char, rsp_bus.last_of_run));
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_FOLD_WIDTH) fold_limit = csr_wdata[FOLD_W-1:0];
            else if (csr_index == CSR_TAB_WIDTH) tab_span = csr_wdata[TAB_W-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            fold_char(req_bus.in_char, req_bus.end_of_text);
            case (offered_check)
               CHK_MODEL: begin
                  foreach (step_text[i]) pending_text.push_back(step_text[i]);
               end
               CHK_NL: begin
                  pending_text.push_back('{ch: CH_NL, last: 1'b1});
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one input item and wait for its transfer.
   task automatic offer(input logic [7:0] c, input logic eot, input check_mode_type chk);
      int gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_char     <= c;
      req_bus.end_of_text <= eot;
      offered_check       <= chk;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
   endtask

   // Registers change only once the block has gone quiet.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly words of random length between blanks, tabs and newlines, with noise.
   function automatic void next_text(output logic [7:0] c, output logic eot);
      int unsigned pick;
      eot = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         c = 8'($urandom_range(0, 255));
         eot = ($urandom_range(0, 5) == 0);
         return;
      end
      if (word_left > 0) begin
         word_left--;
         if ($urandom_range(0, 4) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_TAB || c == CH_NL || c == CH_SP) c = 8'h7E;
         end else begin
            c = 8'(8'h61 + $urandom_range(0, 25));
         end
      end else begin
         pick = $urandom_range(0, 99);
         word_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         if (pick < 65) c = CH_SP;
         else if (pick < 78) c = CH_TAB;
         else if (pick < 92) c = CH_NL;
         else begin
            c = 8'($urandom_range(0, 255));
            eot = 1'b1;
         end
      end
   endfunction

   // Stimulus: reset, directed table, random phases, then the final verdict.
   initial begin
      stim_row_type      row;
      logic [7:0]        c;
      logic              eot;
      logic [FOLD_W-1:0] fold_set;
      logic [TAB_W-1:0]  tab_set;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.in_char     = '0;
      req_bus.end_of_text = 1'b0;
      offered_check       = CHK_MODEL;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         case (row.kind)
            ROW_FOLD: write_reg(CSR_FOLD_WIDTH, row.value[CSR_DATA_W-1:0]);
            ROW_TAB:  write_reg(CSR_TAB_WIDTH, row.value[CSR_DATA_W-1:0]);
            ROW_EOT:  offer(row.value, 1'b1, row.check);
            default:  offer(row.value, 1'b0, row.check);
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         fold_set = PHASE_FOLD[p];
         tab_set = PHASE_TAB[p];
         if (p == 6) begin
            fold_set = FOLD_W'($urandom_range(4, 32));
            tab_set = TAB_W'($urandom_range(1, 15));
         end
         gaps_on = 1'b0;
         stalls_on = 1'b0;
         write_reg(CSR_FOLD_WIDTH, fold_set);
         write_reg(CSR_TAB_WIDTH, {{(CSR_DATA_W - TAB_W){1'b0}}, tab_set});
         gaps_on = PHASE_IDLE[p];
         stalls_on = PHASE_IDLE[p];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Long receiver hold-off while items keep coming.
            if (p == 2 && k == 5) hold_off_pending = 1'b1;
            // Sender pause until every pending byte has been taken.
            if (p == 3 && k == 22) wait_for_drain();
            next_text(c, eot);
            offer(c, eot, CHK_MODEL);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_text.size() != 0) begin
         log_failure($sformatf("%0d bytes never arrived", pending_text.size()));
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(WATCHDOG_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
